// ----- src/ofs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ofs_pkg;

  localparam int CFG_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int SPW        = 48;
  localparam int FC_W       = 32;
  localparam int ALPHA_W    = 17;
  localparam int FRAC       = 16;
  localparam int NORM_BITS  = 47;
  localparam int TWO_PI_W   = 19;

  localparam logic [TWO_PI_W-1:0] TWO_PI_Q16   = 19'd411775;
  localparam logic [SPW-2:0]      SPEED_MAX    = {(SPW-1){1'b1}};
  localparam logic [CFG_W-1:0]    MIN_CUT_RST  = 25'd65536;
  localparam logic [CFG_W-1:0]    BETA_RST     = 25'd0;
  localparam logic [CFG_W-1:0]    D_CUT_RST    = 25'd65536;
  localparam logic [FRAC:0]       HALF_LSB     = 17'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D_CUTOFF   = 2'd2;

  localparam logic [1:0] ST_FIRST    = 2'd0;
  localparam logic [1:0] ST_FILTERED = 2'd1;
  localparam logic [1:0] ST_HELD     = 2'd2;

  localparam logic [2:0] MUL_SPEED = 3'd0;
  localparam logic [2:0] MUL_TWOPI = 3'd1;
  localparam logic [2:0] MUL_NDT   = 3'd2;
  localparam logic [2:0] MUL_FC    = 3'd3;
  localparam logic [2:0] MUL_BLEND = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       first;
    logic       hold;
    logic       setup;
    logic       mul_start;
    logic [2:0] mul_sel;
    logic       div_start;
    logic       div_alpha;
    logic       speed_set;
    logic       norm_load;
    logic       alpha_set;
    logic       blend_apply;
    logic       fc_set;
    logic       phase;
    logic       out_load;
  } ofs_cmd_t;

  typedef struct packed {
    logic started;
    logic time_ok;
    logic mul_busy;
    logic div_busy;
    logic norm_busy;
  } ofs_sts_t;

endpackage
`default_nettype wire

// ----- src/ofs_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ofs_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 48
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [TIME_BITS-1:0]   timestamp;

  modport source (output valid, sample, timestamp, input ready);
  modport sink   (input valid, sample, timestamp, output ready);
endinterface
`default_nettype wire

// ----- src/ofs_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ofs_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_value;
  logic        [1:0]             status;

  modport source (output valid, filtered_value, status, input ready);
  modport sink   (input valid, filtered_value, status, output ready);
endinterface
`default_nettype wire

// ----- src/ofs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ofs_datapath import ofs_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 48,
  parameter int TICK_HZ     = 1000000
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [TIME_BITS-1:0]          timestamp,
  input  wire ofs_cmd_t                      cmd,
  output ofs_sts_t                           sts,
  output logic signed [SAMPLE_BITS-1:0]      filtered_value,
  output logic [1:0]                         status
);

  localparam int VW   = SAMPLE_BITS + FRAC;
  localparam int TKW  = $clog2(TICK_HZ + 1);
  localparam int NUMW = VW + TKW;
  localparam int PW   = TWO_PI_W + FC_W + TIME_BITS;
  localparam int DDW  = TKW + 32;
  localparam int DENW = ((DDW > NORM_BITS) ? DDW : NORM_BITS) + 1;
  localparam int DSW  = (TIME_BITS > DENW) ? TIME_BITS : DENW;
  localparam int BW   = (VW + 1 > SPW + 1) ? VW + 1 : SPW + 1;
  localparam int QXW  = (NUMW > SPW) ? NUMW : SPW;
  localparam int CNTW = $clog2(NUMW + 1);
  localparam int FSW  = PW - FRAC + 1;

  logic [CFG_W-1:0] min_cutoff, beta, d_cutoff;

  logic                 started;
  logic [TIME_BITS-1:0] prev_time;
  logic [VW-1:0]        prev_f;
  logic [SPW-1:0]       sspeed;

  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_BITS-1:0]   in_ts;
  logic [TIME_BITS-1:0]   dt;
  logic [VW-1:0]          dmag;
  logic                   dneg;
  logic [SPW-1:0]         speed;
  logic [FC_W-1:0]        cutoff;
  logic [ALPHA_W-1:0]     alpha;
  logic [BW-2:0]          bmag;
  logic                   bneg;
  logic [1:0]             res_status;

  logic [PW-1:0]        acc, mc, mc_init;
  logic [TIME_BITS-1:0] mp, mp_init;
  logic                 mul_busy;

  logic [DSW-1:0]  r, dv;
  logic [NUMW-1:0] dvd, q;
  logic [CNTW-1:0] cnt;
  logic            div_busy;
  logic [DSW:0]    rs, rdiff;
  logic            ge;

  logic [PW-1:0]  nn;
  logic [DDW-1:0] dd;
  logic           norm_busy;
  logic           norm_more;

  logic [VW-1:0]    x;
  logic [VW:0]      diff_v, diff_abs;
  logic [SPW-2:0]   abs_s;
  logic [SPW-1:0]   abs_full;
  logic [QXW-1:0]   qx;
  logic [SPW-2:0]   sat;
  logic [BW-1:0]    bdiff, babs;
  logic [PW-1:0]    rnd;
  logic [BW-1:0]    m;
  logic [BW:0]      old_ext, bres;
  logic [FSW-1:0]   fsum;
  logic [VW:0]      rnd_out;

  assign x        = {in_sample, {FRAC{1'b0}}};
  assign diff_v   = {x[VW-1], x} - {prev_f[VW-1], prev_f};
  assign diff_abs = diff_v[VW] ? -diff_v : diff_v;
  assign abs_full = sspeed[SPW-1] ? -sspeed : sspeed;
  assign abs_s    = abs_full[SPW-2:0];
  assign qx       = QXW'(q);
  assign sat      = (|qx[QXW-1:SPW-1]) ? SPEED_MAX : qx[SPW-2:0];
  assign norm_more = |nn[PW-1:NORM_BITS];
  assign rs       = {r, dvd[NUMW-1]};
  assign rdiff    = rs - {1'b0, dv};
  assign ge       = !rdiff[DSW];

  always_comb begin
    if (cmd.phase) begin
      bdiff = BW'({{(BW - VW){x[VW-1]}}, x}) - BW'({{(BW - VW){prev_f[VW-1]}}, prev_f});
    end else begin
      bdiff = {speed[SPW-1], speed} - {sspeed[SPW-1], sspeed};
    end
    babs = bdiff[BW-1] ? -bdiff : bdiff;
  end

  assign rnd = acc + PW'(HALF_LSB);
  assign m   = rnd[FRAC +: BW];
  always_comb begin
    if (cmd.phase) begin
      old_ext = (BW + 1)'({{(BW + 1 - VW){prev_f[VW-1]}}, prev_f});
    end else begin
      old_ext = (BW + 1)'({{(BW + 1 - SPW){sspeed[SPW-1]}}, sspeed});
    end
    bres = bneg ? old_ext - {1'b0, m} : old_ext + {1'b0, m};
  end

  assign fsum    = {1'b0, acc[PW-1:FRAC]} + FSW'(min_cutoff);
  assign rnd_out = {prev_f[VW-1], prev_f} + (VW + 1)'(HALF_LSB);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SPEED: begin
        mc_init = PW'(dmag);
        mp_init = TIME_BITS'(TICK_HZ);
      end
      MUL_TWOPI: begin
        mc_init = PW'(cutoff);
        mp_init = TIME_BITS'(TWO_PI_Q16);
      end
      MUL_NDT: begin
        mc_init = PW'(acc[TWO_PI_W+FC_W-1:0]);
        mp_init = dt;
      end
      MUL_FC: begin
        mc_init = PW'(abs_s);
        mp_init = TIME_BITS'(beta);
      end
      MUL_BLEND: begin
        mc_init = PW'(bmag);
        mp_init = TIME_BITS'(alpha);
      end
      default: begin
        mc_init = '0;
        mp_init = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff <= MIN_CUT_RST;
      beta       <= BETA_RST;
      d_cutoff   <= D_CUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_CUTOFF: min_cutoff <= cfg_data;
        CFG_BETA:       beta       <= cfg_data;
        CFG_D_CUTOFF:   d_cutoff   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      prev_time <= '0;
      prev_f    <= '0;
      sspeed    <= '0;
    end else begin
      if (cmd.first) begin
        started   <= 1'b1;
        prev_time <= in_ts;
        prev_f    <= x;
        sspeed    <= '0;
      end
      if (cmd.setup) begin
        prev_time <= in_ts;
      end
      if (cmd.blend_apply) begin
        if (cmd.phase) begin
          prev_f <= bres[VW-1:0];
        end else begin
          sspeed <= bres[SPW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_sample <= sample;
      in_ts     <= timestamp;
    end
    if (cmd.first) begin
      res_status <= ST_FIRST;
    end
    if (cmd.hold) begin
      res_status <= ST_HELD;
    end
    if (cmd.setup) begin
      dt   <= in_ts - prev_time;
      dneg <= diff_v[VW];
      dmag <= diff_abs[VW-1:0];
    end
    if (cmd.speed_set) begin
      speed  <= dneg ? -{1'b0, sat} : {1'b0, sat};
      cutoff <= FC_W'(d_cutoff);
    end
    if (cmd.alpha_set) begin
      alpha <= q[ALPHA_W-1:0];
      bneg  <= bdiff[BW-1];
      bmag  <= babs[BW-2:0];
    end
    if (cmd.blend_apply && cmd.phase) begin
      res_status <= ST_FILTERED;
    end
    if (cmd.fc_set) begin
      cutoff <= (|fsum[FSW-1:FC_W]) ? {FC_W{1'b1}} : fsum[FC_W-1:0];
    end
    if (cmd.out_load) begin
      filtered_value <= rnd_out[FRAC +: SAMPLE_BITS];
      status         <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
    end else if (mul_busy && mp == '0) begin
      mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc <= '0;
      mc  <= mc_init;
      mp  <= mp_init;
    end else if (mul_busy && mp != '0) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_busy <= 1'b0;
    end else if (cmd.norm_load) begin
      norm_busy <= 1'b1;
    end else if (norm_busy && !norm_more) begin
      norm_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      nn <= acc;
      dd <= {TKW'(TICK_HZ), 32'd0};
    end else if (norm_busy && norm_more) begin
      nn <= nn >> 1;
      dd <= dd >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && cnt == CNTW'(1)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q <= '0;
      if (cmd.div_alpha) begin
        r   <= DSW'(nn[NORM_BITS-1:1]);
        dvd <= NUMW'({nn[0], {FRAC{1'b0}}}) << (NUMW - ALPHA_W);
        dv  <= DSW'(nn[NORM_BITS-1:0]) + DSW'(dd);
        cnt <= CNTW'(ALPHA_W);
      end else begin
        r   <= '0;
        dvd <= acc[NUMW-1:0];
        dv  <= DSW'(dt);
        cnt <= CNTW'(NUMW);
      end
    end else if (div_busy) begin
      r   <= ge ? rdiff[DSW-1:0] : rs[DSW-1:0];
      dvd <= dvd << 1;
      q   <= {q[NUMW-2:0], ge};
      cnt <= cnt - CNTW'(1);
    end
  end

  assign sts.started   = started;
  assign sts.time_ok   = in_ts > prev_time;
  assign sts.mul_busy  = mul_busy;
  assign sts.div_busy  = div_busy;
  assign sts.norm_busy = norm_busy;

endmodule
`default_nettype wire

// ----- src/ofs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ofs_ctrl import ofs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     out_ready,
  input  wire ofs_sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output ofs_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_SMUL_GO = 4'd2;
  localparam logic [3:0] S_SMUL    = 4'd3;
  localparam logic [3:0] S_SDIV    = 4'd4;
  localparam logic [3:0] S_AMUL_GO = 4'd5;
  localparam logic [3:0] S_AMUL1   = 4'd6;
  localparam logic [3:0] S_AMUL2   = 4'd7;
  localparam logic [3:0] S_NORM    = 4'd8;
  localparam logic [3:0] S_ADIV    = 4'd9;
  localparam logic [3:0] S_BMUL_GO = 4'd10;
  localparam logic [3:0] S_BMUL    = 4'd11;
  localparam logic [3:0] S_FC_GO   = 4'd12;
  localparam logic [3:0] S_FCMUL   = 4'd13;
  localparam logic [3:0] S_OUT     = 4'd14;

  logic [3:0] state, state_next;
  logic       phase, phase_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.phase  = phase;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.started) begin
          cmd.first  = 1'b1;
          state_next = S_OUT;
        end else if (!sts.time_ok) begin
          cmd.hold   = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.setup  = 1'b1;
          state_next = S_SMUL_GO;
        end
      end
      S_SMUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_SPEED;
        state_next    = S_SMUL;
      end
      S_SMUL: begin
        if (!sts.mul_busy) begin
          cmd.div_start = 1'b1;
          state_next    = S_SDIV;
        end
      end
      S_SDIV: begin
        if (!sts.div_busy) begin
          cmd.speed_set = 1'b1;
          phase_next    = 1'b0;
          state_next    = S_AMUL_GO;
        end
      end
      S_AMUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_TWOPI;
        state_next    = S_AMUL1;
      end
      S_AMUL1: begin
        if (!sts.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_NDT;
          state_next    = S_AMUL2;
        end
      end
      S_AMUL2: begin
        if (!sts.mul_busy) begin
          cmd.norm_load = 1'b1;
          state_next    = S_NORM;
        end
      end
      S_NORM: begin
        if (!sts.norm_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_alpha = 1'b1;
          state_next    = S_ADIV;
        end
      end
      S_ADIV: begin
        if (!sts.div_busy) begin
          cmd.alpha_set = 1'b1;
          state_next    = S_BMUL_GO;
        end
      end
      S_BMUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_BLEND;
        state_next    = S_BMUL;
      end
      S_BMUL: begin
        if (!sts.mul_busy) begin
          cmd.blend_apply = 1'b1;
          state_next      = phase ? S_OUT : S_FC_GO;
        end
      end
      S_FC_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_FC;
        state_next    = S_FCMUL;
      end
      S_FCMUL: begin
        if (!sts.mul_busy) begin
          cmd.fc_set = 1'b1;
          phase_next = 1'b1;
          state_next = S_AMUL_GO;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !sts.mul_busy) else $error("multiplier restarted while busy");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({sts.mul_busy, sts.div_busy, sts.norm_busy}))
    else $error("two arithmetic units busy at once");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result transfer lost");
`endif

endmodule
`default_nettype wire

// ----- src/one_euro_scalar_filter_unit.sv -----
// A filtered sample takes longer than a first or held one; its processing time is set
// by operand bit lengths: a shift-add multiplier retires one multiplier bit per cycle,
// a restoring divider one quotient bit, a normaliser one shift. Output stalls add to this.
// One sample in flight: a new input is taken only after the previous result has been
// loaded into the output register.
// Reset (synchronous, active high) restores register defaults and clears filter state.
`timescale 1ns / 1ps
`default_nettype none
module one_euro_scalar_filter_unit import ofs_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 48,
  parameter int TICK_HZ     = 1000000
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ofs_in_if.sink                    in_ch,
  ofs_out_if.source                 out_ch
);

  ofs_cmd_t cmd;
  ofs_sts_t sts;

  ofs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  ofs_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS),
    .TICK_HZ     (TICK_HZ)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (in_ch.sample),
    .timestamp      (in_ch.timestamp),
    .cmd            (cmd),
    .sts            (sts),
    .filtered_value (out_ch.filtered_value),
    .status         (out_ch.status)
  );

endmodule
`default_nettype wire

// ----- verif/ofs_filter_checker.sv -----
`timescale 1ns / 1ps
module ofs_filter_checker import ofs_pkg::*; #(
  parameter int TICK_HZ = 1000000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ofs_in_if                    in_mon,
  ofs_out_if                   out_mon,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         status;
  } filter_result_t;

  localparam logic [63:0] FC_CAP = 64'hFFFF_FFFF;

  filter_result_t expected_q[$];

  logic [CFG_W-1:0] min_cutoff, beta, d_cutoff;
  logic             started;
  logic [47:0]      prev_time;
  longint           prev_filtered, smoothed_speed;

  function automatic logic [16:0] alpha_for(logic [63:0] fc, logic [47:0] dt);
    logic [127:0] n;
    logic [127:0] q;
    logic [63:0]  d;
    logic [63:0]  den;
    if (fc == 0) return '0;
    n = 128'(TWO_PI_Q16) * 128'(fc) * 128'(dt);
    d = 64'(TICK_HZ) << 32;
    while (n >= (128'd1 << NORM_BITS)) begin
      n = n >> 1;
      d = d >> 1;
    end
    den = n[63:0] + d;
    if (den == 0) return '0;
    q = (n << 16) / 128'(den);
    return q[16:0];
  endfunction

  function automatic longint blend(longint old, longint target, logic [16:0] a);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] m;
    diff = target - old;
    mag  = diff < 0 ? 64'(-diff) : 64'(diff);
    m    = (mag * 64'(a) + 64'd32768) >> 16;
    return diff < 0 ? old - longint'(m) : old + longint'(m);
  endfunction

  function automatic logic signed [15:0] rounded(longint v);
    longint t;
    t = (v + 32768) >>> 16;
    return t[15:0];
  endfunction

  function automatic filter_result_t filter_sample(logic signed [15:0] smp,
                                                   logic [47:0] ts);
    longint         x, diff, speed, abs_s;
    logic [63:0]    mag;
    logic [47:0]    dt;
    logic [127:0]   q, p, f;
    filter_result_t r;
    x = longint'(smp) * 65536;
    if (!started) begin
      started        = 1'b1;
      prev_time      = ts;
      prev_filtered  = x;
      smoothed_speed = 0;
      r.value  = rounded(prev_filtered);
      r.status = ST_FIRST;
      return r;
    end
    if (ts <= prev_time) begin
      r.value  = rounded(prev_filtered);
      r.status = ST_HELD;
      return r;
    end
    dt        = ts - prev_time;
    prev_time = ts;
    diff = x - prev_filtered;
    mag  = diff < 0 ? 64'(-diff) : 64'(diff);
    q    = (128'(mag) * 128'(TICK_HZ)) / 128'(dt);
    if (q > 128'(SPEED_MAX)) q = 128'(SPEED_MAX);
    speed = diff < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    smoothed_speed = blend(smoothed_speed, speed, alpha_for(64'(d_cutoff), dt));
    abs_s = smoothed_speed < 0 ? -smoothed_speed : smoothed_speed;
    p = 128'(beta) * 128'(abs_s);
    if ((p >> 80) != 0) begin
      f = 128'(FC_CAP);
    end else begin
      f = (p >> 16) + 128'(min_cutoff);
      if (f > 128'(FC_CAP)) f = 128'(FC_CAP);
    end
    prev_filtered = blend(prev_filtered, x, alpha_for(f[63:0], dt));
    r.value  = rounded(prev_filtered);
    r.status = ST_FILTERED;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    filter_result_t e;
    if (rst) begin
      min_cutoff     <= MIN_CUT_RST;
      beta           <= BETA_RST;
      d_cutoff       <= D_CUT_RST;
      started        = 1'b0;
      prev_time      = '0;
      prev_filtered  = 0;
      smoothed_speed = 0;
      fail_count     = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_CUTOFF: min_cutoff <= cfg_data;
          CFG_BETA:       beta       <= cfg_data;
          CFG_D_CUTOFF:   d_cutoff   <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(filter_sample(in_mon.sample, in_mon.timestamp));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transfer: value %0d status %0d",
                     out_mon.filtered_value, out_mon.status);
        end else begin
          e = expected_q.pop_front();
          if (e.value !== out_mon.filtered_value || e.status !== out_mon.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       e.value, e.status, out_mon.filtered_value, out_mon.status);
          end
        end
      end
    end
  end

endmodule

// ----- verif/tb_one_euro_scalar_filter_unit.sv -----
`timescale 1ns / 1ps
module tb_one_euro_scalar_filter_unit;
  import ofs_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_CUTOFF;
  logic [CFG_W-1:0]     cfg_data = '0;

  int          fail_count, pending;
  bit          gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;
  logic [47:0] cur_ts = '0;
  logic signed [15:0] last_sample = '0;

  ofs_in_if  #(.SAMPLE_BITS(16), .TIME_BITS(48)) in_ch();
  ofs_out_if #(.SAMPLE_BITS(16))                 out_ch();

  one_euro_scalar_filter_unit #(
    .SAMPLE_BITS(16),
    .TIME_BITS(48),
    .TICK_HZ(1000000)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  ofs_filter_checker #(.TICK_HZ(1000000)) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_mon(in_ch),
    .out_mon(out_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.timestamp = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 4));
    return int'($urandom_range(20, 80));
  endfunction

  // receiver side
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        long_hold_req = 1'b0;
        repeat (3000) @(posedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(logic signed [15:0] smp, logic [47:0] ts);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= smp;
    in_ch.timestamp <= ts;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] mc, logic [CFG_W-1:0] b,
                           logic [CFG_W-1:0] dc, bit stray);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_CUTOFF;
    cfg_data  <= mc;
    @(posedge clk);
    cfg_index <= CFG_BETA;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= CFG_D_CUTOFF;
    cfg_data  <= dc;
    @(posedge clk);
    if (stray) begin
      cfg_index <= ~CFG_IDX_W'(0);
      cfg_data  <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_step(logic signed [15:0] smp, logic [47:0] dt);
    cur_ts = cur_ts + dt;
    send(smp, cur_ts);
  endtask

  task automatic random_item();
    int r;
    logic signed [15:0] smp;
    r = int'($urandom_range(0, 99));
    if (r < 50)      smp = last_sample + 16'($signed($urandom_range(0, 400)) - 200);
    else if (r < 80) smp = 16'($urandom);
    else if (r < 90) smp = 16'sh7FFF;
    else             smp = -16'sh8000;
    last_sample = smp;
    r = int'($urandom_range(0, 99));
    if (r < 8)
      send(smp, cur_ts - 48'($urandom_range(0, cur_ts < 3 ? 0 : 3)));
    else if (r < 70) send_step(smp, 48'($urandom_range(1, 2000)));
    else if (r < 90) send_step(smp, 48'($urandom_range(2000, 200000)));
    else             send_step(smp, 48'($urandom_range(1, 5)));
  endtask

  initial begin
    logic [CFG_W-1:0] mc, b, dc;
    cfg_we <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(-16'sh8000, 48'd0);
    send(16'sh7FFF, 48'd0);
    send_step(16'sh7FFF, 48'd1);
    send_step(-16'sh8000, 48'd1);
    send_step(16'sh0000, 48'd1000);
    send(16'sh0001, 48'd5);
    send_step(-16'sh0001, 48'd1000000000);
    send_step(16'sh1234, 48'd1);
    send_step(16'sh1234, 48'd16667);
    send_step(16'sh7FFF, 48'd3);
    send(16'sh0000, cur_ts);

    for (int phase = 0; phase < 7; phase++) begin
      wait_idle();
      gaps_on = (phase != 3);
      case (phase)
        0: write_cfg(MIN_CUT_RST, 25'd65536, D_CUT_RST, 1'b1);
        1: write_cfg('0, '0, '0, 1'b0);
        2: write_cfg(25'd16777216, 25'd16777216, 25'd16777216, 1'b0);
        3: write_cfg(25'd3276, 25'd16777216, 25'd0, 1'b1);
        4: write_cfg(25'd0, 25'd655, 25'd65536, 1'b0);
        default: begin
          mc = CFG_W'($urandom_range(0, 16777216));
          b  = CFG_W'($urandom_range(0, 16777216));
          dc = CFG_W'($urandom_range(0, 16777216));
          write_cfg(mc, b, dc, 1'b1);
        end
      endcase
      for (int i = 0; i < 60; i++) begin
        if (phase == 2 && i == 10) long_hold_req = 1'b1;
        random_item();
      end
    end

    wait_idle();
    write_cfg(MIN_CUT_RST, 25'd32768, D_CUT_RST, 1'b0);
    send_step(16'sh0100, 48'h8000_0000_0000 - cur_ts);
    send_step(16'sh0200, 48'd1);
    send_step(-16'sh0200, 48'hFFFF_FFFF_FFFE - cur_ts);
    send_step(16'sh5555, 48'd1);
    send(16'sh2AAA, 48'h0000_5555_AAAA);
    send(16'sh0000, cur_ts);

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(64'd12 * 64'd4000000);
    $display("status: fail");
    $finish;
  end

endmodule
